[rtl/button_debounce_auto_repeat_defines.svh]
// assertion macros shared by the debounce block
`ifndef BUTTON_DEBOUNCE_AUTO_REPEAT_DEFINES_SVH
`define BUTTON_DEBOUNCE_AUTO_REPEAT_DEFINES_SVH

// same-cycle implication
`define BDAR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define BDAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

[rtl/bdar_pkg.sv]
// types, constants and register map of the debounce block
package bdar_pkg;

   localparam int QUEUE_DEPTH     = 16;
   localparam int BUTTON_COUNT    = 3;
   localparam int BTN_W           = $clog2(BUTTON_COUNT);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
   localparam int QIDX_W          = $clog2(QUEUE_DEPTH);
   localparam int TIMER_W         = 16;
   localparam int RC_W            = 4;
   localparam int TICK_FIFO_DEPTH = 2;
   localparam int TF_PTR_W        = $clog2(TICK_FIFO_DEPTH);
   localparam int TF_CNT_W        = $clog2(TICK_FIFO_DEPTH + 1);
   localparam int ADDR_W          = 5;
   localparam int REG_IDX_W       = 3;
   localparam int DATA_W          = 32;

   localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
   localparam logic [RC_W-1:0]    RC_MAX    = '1;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_SETTLE    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_HOLD      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SLOW      = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_FAST      = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ACCEL     = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_NO_REPEAT = 3'd6;

   // register reset values
   localparam logic [15:0] SETTLE_RST    = 16'd50;
   localparam logic [15:0] DEBOUNCE_RST  = 16'd200;
   localparam logic [15:0] HOLD_RST      = 16'd500;
   localparam logic [15:0] SLOW_RST      = 16'd180;
   localparam logic [15:0] FAST_RST      = 16'd60;
   localparam logic [3:0]  ACCEL_RST     = 4'd6;
   localparam logic [1:0]  NO_REPEAT_RST = 2'd1;

   typedef struct packed {
      logic [15:0] settle_ms;
      logic [15:0] debounce_ms;
      logic [15:0] hold_delay_ms;
      logic [15:0] slow_interval_ms;
      logic [15:0] fast_interval_ms;
      logic [3:0]  accel_steps;
      logic [1:0]  no_repeat_button;
   } cfg_type;

   typedef struct packed {
      logic [BUTTON_COUNT-1:0] levels;
      logic [BUTTON_COUNT-1:0] falling;
   } tick_type;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_SETTLE  = 5'b00010,
      PH_HOLD    = 5'b00100,
      PH_REPEAT  = 5'b01000,
      PH_HOLDOFF = 5'b10000
   } phase_type;

endpackage

[rtl/bdar_channel_if.sv]
// valid/ready channel interfaces for tick input and press output
interface bdar_req_if
   import bdar_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [BUTTON_COUNT-1:0] pin_levels;

   modport source (output valid, output pin_levels, input ready);
   modport sink (input valid, input pin_levels, output ready);
endinterface

interface bdar_rsp_if
   import bdar_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [BTN_W-1:0] press_button;
   logic             is_repeat;

   modport source (output valid, output press_button, output is_repeat, input ready);
   modport sink (input valid, input press_button, input is_repeat, output ready);
endinterface

[rtl/button_debounce_auto_repeat.sv]
// top level: register port, front end, back end and checks
//
//   channel   direction   payload                      transfer when
//   req_ch    in          pin_levels[2:0]              valid && ready
//   rsp_ch    out         press_button[1:0], is_repeat valid && ready
//   apb       in/out      7 registers at 4*i           psel && penable && pwrite
//
// one tick per cycle sustained while rsp_ch does not stall; a tick passes from req_ch to rsp_ch through
// the front tick queue, then the back-end phase update into the result register
// a two-entry tick queue lets req_ch keep taking ticks while a result waits
// synchronous reset clears control state and loads register defaults; no clearing pass
// rsp_ch stall holds the back end, which fills the tick queue and then drops req_ch.ready
`include "button_debounce_auto_repeat_defines.svh"

module button_debounce_auto_repeat
   import bdar_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   bdar_req_if.sink          req_ch,
   bdar_rsp_if.source        rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type                cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   reg_write;
   logic                   tick_valid;
   logic                   tick_ready;
   tick_type               tick_data;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[ADDR_W-1:2];
   assign reg_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (reg_write) begin
         unique case (reg_idx)
            REG_SETTLE:    cfg_in.settle_ms        = pwdata[15:0];
            REG_DEBOUNCE:  cfg_in.debounce_ms      = pwdata[15:0];
            REG_HOLD:      cfg_in.hold_delay_ms    = pwdata[15:0];
            REG_SLOW:      cfg_in.slow_interval_ms = pwdata[15:0];
            REG_FAST:      cfg_in.fast_interval_ms = pwdata[15:0];
            REG_ACCEL:     cfg_in.accel_steps      = pwdata[3:0];
            REG_NO_REPEAT: cfg_in.no_repeat_button = pwdata[1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SETTLE:    prdata = DATA_W'(cfg_ff.settle_ms);
         REG_DEBOUNCE:  prdata = DATA_W'(cfg_ff.debounce_ms);
         REG_HOLD:      prdata = DATA_W'(cfg_ff.hold_delay_ms);
         REG_SLOW:      prdata = DATA_W'(cfg_ff.slow_interval_ms);
         REG_FAST:      prdata = DATA_W'(cfg_ff.fast_interval_ms);
         REG_ACCEL:     prdata = DATA_W'(cfg_ff.accel_steps);
         REG_NO_REPEAT: prdata = DATA_W'(cfg_ff.no_repeat_button);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ms        <= SETTLE_RST;
         cfg_ff.debounce_ms      <= DEBOUNCE_RST;
         cfg_ff.hold_delay_ms    <= HOLD_RST;
         cfg_ff.slow_interval_ms <= SLOW_RST;
         cfg_ff.fast_interval_ms <= FAST_RST;
         cfg_ff.accel_steps      <= ACCEL_RST;
         cfg_ff.no_repeat_button <= NO_REPEAT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bdar_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .tick_valid (tick_valid),
      .tick_data  (tick_data),
      .tick_ready (tick_ready)
   );

   bdar_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .tick_valid (tick_valid),
      .tick_data  (tick_data),
      .tick_ready (tick_ready),
      .rsp        (rsp_ch)
   );

   // a stalled result keeps the back end from taking another tick
   `BDAR_ASSERT_SAME(a_stall_holds_back, clock, reset, rsp_ch.valid && !rsp_ch.ready, !tick_ready)
   // a result only appears after a tick was processed
   `BDAR_ASSERT_SAME(a_rsp_from_tick, clock, reset, $rose(rsp_ch.valid), $past(tick_valid && tick_ready))
   // reported button is always a real one
   `BDAR_ASSERT_SAME(a_button_range, clock, reset, rsp_ch.valid, rsp_ch.press_button < BTN_W'(BUTTON_COUNT))
   // a tick taken while the tick queue was empty is ready for the back end next cycle
   `BDAR_ASSERT_NEXT(a_tick_reaches_back, clock, reset, req_ch.valid && req_ch.ready && !tick_valid, tick_valid)

endmodule

[rtl/bdar_front.sv]
// front end: falling-edge detection and short tick queue toward the back end
module bdar_front
   import bdar_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   bdar_req_if.sink req,
   output logic     tick_valid,
   output tick_type tick_data,
   input  logic     tick_ready
);

   logic [BUTTON_COUNT-1:0] prev_levels_ff, prev_levels_in;
   tick_type                tick_mem_ff [TICK_FIFO_DEPTH];
   logic [TF_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [TF_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [TF_CNT_W-1:0]     fill_ff, fill_in;
   logic                    push;
   logic                    pop;
   tick_type                new_tick;

   assign req.ready  = (fill_ff != TF_CNT_W'(TICK_FIFO_DEPTH));
   assign push       = req.valid && req.ready;
   assign tick_valid = (fill_ff != '0);
   assign tick_data  = tick_mem_ff[rd_ptr_ff];
   assign pop        = tick_valid && tick_ready;

   assign new_tick.levels  = req.pin_levels;
   assign new_tick.falling = prev_levels_ff & ~req.pin_levels;

   always_comb begin
      prev_levels_in = push ? req.pin_levels : prev_levels_ff;
      wr_ptr_in      = push ? wr_ptr_ff + TF_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in      = pop ? rd_ptr_ff + TF_PTR_W'(1) : rd_ptr_ff;
      fill_in        = fill_ff + TF_CNT_W'(push) - TF_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_levels_ff <= '1;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         fill_ff        <= '0;
      end else begin
         prev_levels_ff <= prev_levels_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         fill_ff        <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         tick_mem_ff[wr_ptr_ff] <= new_tick;
      end
   end

endmodule

[rtl/bdar_back.sv]
// back end: edge queue, press timers, phase machine and result register
module bdar_back
   import bdar_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       tick_valid,
   input  tick_type   tick_data,
   output logic       tick_ready,
   bdar_rsp_if.source rsp
);

   phase_type           phase_ff, phase_in;
   logic [BTN_W-1:0]    active_ff, active_in;
   logic [TIMER_W-1:0]  timer_ff, timer_in;
   logic [RC_W-1:0]     rc_ff, rc_in;
   logic [TIMER_W-1:0]  since_ff [BUTTON_COUNT];
   logic [TIMER_W-1:0]  since_in [BUTTON_COUNT];
   logic [TIMER_W-1:0]  since_inc [BUTTON_COUNT];
   logic [BTN_W-1:0]    eq_ff [QUEUE_DEPTH];
   logic [BTN_W-1:0]    eq_in [QUEUE_DEPTH];
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BTN_W-1:0]    rsp_btn_ff, rsp_btn_in;
   logic                rsp_rep_ff, rsp_rep_in;

   logic                step;
   logic [BTN_W-1:0]    push_list [BUTTON_COUNT];
   logic [QCNT_W-1:0]   push_n;
   logic [QCNT_W-1:0]   cnt_pushed;
   logic                pop;
   logic [BTN_W-1:0]    head;
   logic [TIMER_W-1:0]  timer_inc;
   logic [TIMER_W-1:0]  wait_len;
   logic                done;
   logic                pin_low;
   logic [TIMER_W-1:0]  since_sel;
   logic                emit;
   logic                emit_rep;

   assign tick_ready       = !rsp_valid_ff || rsp.ready;
   assign step             = tick_valid && tick_ready;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.press_button = rsp_btn_ff;
   assign rsp.is_repeat    = rsp_rep_ff;

   // falling edges in index order, dropped once the queue is full
   always_comb begin
      push_n = '0;
      for (int b = 0; b < BUTTON_COUNT; b++) begin
         push_list[b] = '0;
      end
      for (int b = 0; b < BUTTON_COUNT; b++) begin
         if (tick_data.falling[b] && (cnt_ff + push_n) < QCNT_W'(QUEUE_DEPTH)) begin
            push_list[push_n[BTN_W-1:0]] = BTN_W'(b);
            push_n = push_n + QCNT_W'(1);
         end
      end
      cnt_pushed = cnt_ff + push_n;
      head       = (cnt_ff != '0) ? eq_ff[0] : push_list[0];
      pop        = (phase_ff == PH_IDLE) && (cnt_pushed != '0);
   end

   // per-button values for the active button
   always_comb begin
      pin_low   = 1'b0;
      since_sel = '0;
      for (int b = 0; b < BUTTON_COUNT; b++) begin
         since_inc[b] = (since_ff[b] == TIMER_MAX) ? since_ff[b] : since_ff[b] + TIMER_W'(1);
         if (active_ff == BTN_W'(b)) begin
            pin_low   = !tick_data.levels[b];
            since_sel = since_inc[b];
         end
      end
   end

   always_comb begin
      timer_inc = (timer_ff == TIMER_MAX) ? timer_ff : timer_ff + TIMER_W'(1);
      unique case (phase_ff)
         PH_SETTLE:  wait_len = cfg.settle_ms;
         PH_HOLD:    wait_len = cfg.hold_delay_ms;
         PH_REPEAT:  wait_len = (rc_ff < cfg.accel_steps) ? cfg.slow_interval_ms
                                                          : cfg.fast_interval_ms;
         PH_HOLDOFF: wait_len = cfg.debounce_ms;
         default:    wait_len = '0;
      endcase
      done = (timer_inc >= wait_len);
   end

   always_comb begin
      logic [QCNT_W-1:0] j;
      logic [QCNT_W-1:0] k;

      phase_in  = phase_ff;
      active_in = active_ff;
      timer_in  = timer_ff;
      rc_in     = rc_ff;
      cnt_in    = cnt_ff;
      emit      = 1'b0;
      emit_rep  = 1'b0;
      j         = '0;
      k         = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         eq_in[i] = eq_ff[i];
      end
      for (int b = 0; b < BUTTON_COUNT; b++) begin
         since_in[b] = since_ff[b];
      end

      if (step) begin
         cnt_in = cnt_pushed - QCNT_W'(pop);
         // queue after pushes, shifted by one when the head leaves
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            j = QCNT_W'(i) + QCNT_W'(pop);
            if (j < cnt_ff) begin
               eq_in[i] = pop ? eq_ff[QIDX_W'((i + 1) % QUEUE_DEPTH)] : eq_ff[QIDX_W'(i)];
            end else begin
               k = j - cnt_ff;
               if (k < QCNT_W'(BUTTON_COUNT)) begin
                  eq_in[i] = push_list[k[BTN_W-1:0]];
               end
            end
         end
         for (int b = 0; b < BUTTON_COUNT; b++) begin
            since_in[b] = since_inc[b];
         end

         unique case (phase_ff)
            PH_IDLE: begin
               if (pop) begin
                  active_in = head;
                  phase_in  = PH_SETTLE;
                  timer_in  = '0;
               end
            end
            PH_SETTLE: begin
               timer_in = timer_inc;
               if (done) begin
                  phase_in = PH_HOLDOFF;
                  timer_in = '0;
                  cnt_in   = '0;
                  if (pin_low && since_sel >= cfg.debounce_ms) begin
                     for (int b = 0; b < BUTTON_COUNT; b++) begin
                        if (active_ff == BTN_W'(b)) begin
                           since_in[b] = '0;
                        end
                     end
                     emit = 1'b1;
                     if (active_ff != cfg.no_repeat_button) begin
                        phase_in = PH_HOLD;
                        rc_in    = '0;
                        cnt_in   = cnt_pushed;
                     end
                  end
               end
            end
            PH_HOLD, PH_REPEAT: begin
               timer_in = timer_inc;
               if (done) begin
                  timer_in = '0;
                  if (pin_low) begin
                     phase_in = PH_REPEAT;
                     rc_in    = (rc_ff == RC_MAX) ? rc_ff : rc_ff + RC_W'(1);
                     emit     = 1'b1;
                     emit_rep = 1'b1;
                  end else begin
                     phase_in = PH_HOLDOFF;
                     cnt_in   = '0;
                  end
               end
            end
            PH_HOLDOFF: begin
               timer_in = timer_inc;
               if (done) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      rsp_btn_in = rsp_btn_ff;
      rsp_rep_in = rsp_rep_ff;
      if (step) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_btn_in = active_ff;
            rsp_rep_in = emit_rep;
         end
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         active_ff    <= '0;
         timer_ff     <= '0;
         rc_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < BUTTON_COUNT; b++) begin
            since_ff[b] <= TIMER_MAX;
         end
      end else begin
         phase_ff     <= phase_in;
         active_ff    <= active_in;
         timer_ff     <= timer_in;
         rc_ff        <= rc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int b = 0; b < BUTTON_COUNT; b++) begin
            since_ff[b] <= since_in[b];
         end
      end
   end

   // queue entries and result payload carry no reset
   always_ff @(posedge clock) begin
      rsp_btn_ff <= rsp_btn_in;
      rsp_rep_ff <= rsp_rep_in;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         eq_ff[i] <= eq_in[i];
      end
   end

endmodule

[test/tb_top.sv]
// testbench for the debounce block: predicts each press and repeat from the ticks and checks them
module tb_top
   import bdar_pkg::*;
();

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 9;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_CYCLES = 200;
   localparam int REG_COUNT    = 7;
   localparam int PHASE_TICKS  = 48;
   localparam logic [REG_IDX_W-1:0]    REG_UNUSED = 3'd7;
   localparam logic [BUTTON_COUNT-1:0] ALL_UP     = '1;

   typedef struct packed {
      logic [BTN_W-1:0] button;
      logic             is_rep;
   } press_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic tick_valid = 1'b0;
   logic [BUTTON_COUNT-1:0] tick_levels = ALL_UP;
   logic take_ready = 1'b0;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;

   bdar_req_if req_if ();
   bdar_rsp_if rsp_if ();

   assign req_if.valid = tick_valid;
   assign req_if.pin_levels = tick_levels;
   assign rsp_if.ready = take_ready;

   button_debounce_auto_repeat uut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #HALF_PERIOD clock = ~clock;

   int errors = 0;
   int quiet = 0;
   int ticks_queued = 0;
   int ticks_taken = 0;
   int tx_idle_pct = 12;
   int rx_idle_pct = 84;
   int stalls_asked = 0;
   int stalls_done = 0;
   int stall_left = 0;
   bit tick_taken = 1'b0;
   logic [BUTTON_COUNT-1:0] tick_q[$];
   press_type press_q[$];

   // mirror of the block: settings and tracking state
   cfg_type live_cfg;
   phase_type dph = PH_IDLE;
   logic [BTN_W-1:0] cur_btn = '0;
   logic [TIMER_W-1:0] dwell = '0;
   logic [RC_W-1:0] rep_n = '0;
   logic [TIMER_W-1:0] since_press [BUTTON_COUNT] = '{default: TIMER_MAX};
   logic [BUTTON_COUNT-1:0] last_lv = ALL_UP;
   logic [BTN_W-1:0] edge_fifo[$];

   task automatic flag_mismatch(input string what, input int got, input int want);
      if (errors < 100) begin
         $display("mismatch: %s got %0d expected %0d", what, got, want);
      end
      errors++;
   endtask

   function automatic bit idles(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // one tick of the current wait, true once it has run its length
   function automatic bit count_wait(input logic [TIMER_W-1:0] len);
      if (dwell != TIMER_MAX) dwell++;
      return dwell >= len;
   endfunction

   task automatic end_handling();
      edge_fifo.delete();
      dph = PH_HOLDOFF;
      dwell = '0;
   endtask

   task automatic predict_tick(input logic [BUTTON_COUNT-1:0] lv);
      logic pin_low;
      logic [TIMER_W-1:0] len;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
         if (last_lv[i] && !lv[i] && edge_fifo.size() < QUEUE_DEPTH)
            edge_fifo.push_back(BTN_W'(i));
      end
      last_lv = lv;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
         if (since_press[i] != TIMER_MAX) since_press[i]++;
      end
      pin_low = !lv[cur_btn];
      case (dph)
         PH_IDLE: begin
            if (edge_fifo.size() > 0) begin
               cur_btn = edge_fifo.pop_front();
               dph = PH_SETTLE;
               dwell = '0;
            end
         end
         PH_SETTLE: begin
            if (count_wait(live_cfg.settle_ms)) begin
               if (pin_low && since_press[cur_btn] >= live_cfg.debounce_ms) begin
                  since_press[cur_btn] = '0;
                  press_q.push_back(press_type'{cur_btn, 1'b0});
                  if (cur_btn != live_cfg.no_repeat_button) begin
                     dph = PH_HOLD;
                     dwell = '0;
                     rep_n = '0;
                  end else begin
                     end_handling();
                  end
               end else begin
                  end_handling();
               end
            end
         end
         PH_HOLD, PH_REPEAT: begin
            if (dph == PH_HOLD) len = live_cfg.hold_delay_ms;
            else if (rep_n < live_cfg.accel_steps) len = live_cfg.slow_interval_ms;
            else len = live_cfg.fast_interval_ms;
            if (count_wait(len)) begin
               if (pin_low) begin
                  if (rep_n != RC_MAX) rep_n++;
                  dph = PH_REPEAT;
                  dwell = '0;
                  press_q.push_back(press_type'{cur_btn, 1'b1});
               end else begin
                  end_handling();
               end
            end
         end
         PH_HOLDOFF: begin
            if (count_wait(live_cfg.debounce_ms)) dph = PH_IDLE;
         end
         default: begin
            dph = PH_IDLE;
         end
      endcase
   endtask

   // tick sender
   always @(negedge clock) begin
      if (!reset && (!tick_valid || tick_taken)) begin
         if (tick_q.size() > 0 && !idles(tx_idle_pct)) begin
            tick_valid <= 1'b1;
            tick_levels <= tick_q.pop_front();
         end else begin
            tick_valid <= 1'b0;
         end
      end
   end

   // press receiver, with long hold-offs on request
   always @(negedge clock) begin
      if (stall_left > 0) begin
         take_ready <= 1'b0;
         stall_left--;
      end else if (stalls_done < stalls_asked) begin
         take_ready <= 1'b0;
         stall_left = STALL_CYCLES;
         stalls_done++;
      end else begin
         take_ready <= !idles(rx_idle_pct);
      end
   end

   always @(posedge clock) begin : watch_outputs
      press_type want;
      bit press_taken;
      tick_taken = 1'b0;
      press_taken = rsp_if.valid && take_ready;
      if (!reset) begin
         if (press_taken) begin
            if (press_q.size() == 0) begin
               flag_mismatch("press with nothing pending, button",
                             int'(rsp_if.press_button), -1);
            end else begin
               want = press_q.pop_front();
               if (rsp_if.press_button !== want.button)
                  flag_mismatch("press button", int'(rsp_if.press_button), int'(want.button));
               if (rsp_if.is_repeat !== want.is_rep)
                  flag_mismatch("repeat flag", int'(rsp_if.is_repeat), int'(want.is_rep));
            end
         end
         if (tick_valid && req_if.ready) begin
            tick_taken = 1'b1;
            predict_tick(tick_levels);
            ticks_taken++;
         end
         if (tick_taken || press_taken || (psel && penable && pready)) begin
            quiet = 0;
         end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
               $display("watchdog: no transfer in %0d cycles", QUIET_LIMIT);
               $display("Simulation FAILED");
               $finish;
            end
         end
      end
   end

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic csr_read(input logic [REG_IDX_W-1:0] idx, output logic [DATA_W-1:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] reg_value(input cfg_type c,
                                                   input logic [REG_IDX_W-1:0] idx);
      case (idx)
         REG_SETTLE:    return DATA_W'(c.settle_ms);
         REG_DEBOUNCE:  return DATA_W'(c.debounce_ms);
         REG_HOLD:      return DATA_W'(c.hold_delay_ms);
         REG_SLOW:      return DATA_W'(c.slow_interval_ms);
         REG_FAST:      return DATA_W'(c.fast_interval_ms);
         REG_ACCEL:     return DATA_W'(c.accel_steps);
         REG_NO_REPEAT: return DATA_W'(c.no_repeat_button);
         default:       return '0;
      endcase
   endfunction

   task automatic check_readback();
      logic [DATA_W-1:0] got;
      logic [REG_IDX_W-1:0] idx;
      for (int i = 0; i < REG_COUNT; i++) begin
         idx = REG_IDX_W'(i);
         csr_read(idx, got);
         if (got !== reg_value(live_cfg, idx))
            flag_mismatch($sformatf("register %0d readback", i), got, reg_value(live_cfg, idx));
      end
   endtask

   // bits above a register's width carry noise and must not stick
   task automatic load_settings(input cfg_type c);
      logic [DATA_W-1:0] mask;
      logic [REG_IDX_W-1:0] idx;
      for (int i = 0; i < REG_COUNT; i++) begin
         idx = REG_IDX_W'(i);
         mask = (idx == REG_ACCEL) ? 32'hF : (idx == REG_NO_REPEAT) ? 32'h3 : 32'hFFFF;
         csr_write(idx, reg_value(c, idx) | ($urandom & ~mask));
      end
      csr_write(REG_UNUSED, $urandom);
      live_cfg = c;
      check_readback();
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (ticks_taken != ticks_queued || press_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic queue_tick(input logic [BUTTON_COUNT-1:0] lv);
      tick_q.push_back(lv);
      ticks_queued++;
   endtask

   // contact bounce, a low stretch with the odd second button, then release
   task automatic queue_press(input int btn, input int low_ticks);
      logic [BUTTON_COUNT-1:0] lv;
      repeat ($urandom_range(0, 3)) begin
         lv = ALL_UP;
         lv[btn] = 1'($urandom_range(0, 1));
         queue_tick(lv);
      end
      repeat (low_ticks) begin
         lv = ALL_UP;
         if ($urandom_range(0, 9) == 0) lv = BUTTON_COUNT'($urandom);
         lv[btn] = 1'b0;
         queue_tick(lv);
      end
      repeat ($urandom_range(1, 8)) queue_tick(ALL_UP);
   endtask

   task automatic run_random_phase(input int n_ticks);
      cfg_type c;
      int base;
      c.settle_ms = TIMER_W'($urandom_range(0, 4));
      c.debounce_ms = TIMER_W'($urandom_range(0, 12));
      c.hold_delay_ms = TIMER_W'($urandom_range(0, 6));
      c.slow_interval_ms = TIMER_W'($urandom_range(0, 4));
      c.fast_interval_ms = TIMER_W'($urandom_range(0, 3));
      c.accel_steps = RC_W'($urandom_range(0, 15));
      c.no_repeat_button = BTN_W'($urandom_range(0, 3));
      load_settings(c);
      base = ticks_queued;
      while (ticks_queued - base < n_ticks) begin
         case ($urandom_range(0, 9))
            0: begin
               repeat ($urandom_range(3, 12)) queue_tick(BUTTON_COUNT'($urandom));
            end
            1: begin
               // all buttons chattering, enough edges to overflow the edge queue
               repeat ($urandom_range(6, 20)) begin
                  queue_tick(ALL_UP);
                  queue_tick('0);
               end
            end
            default: begin
               queue_press($urandom_range(0, BUTTON_COUNT - 1), $urandom_range(1, 30));
            end
         endcase
      end
      wait_drained();
   endtask

   initial begin : run_stimulus
      logic [BUTTON_COUNT-1:0] opening [] = '{
         3'b111, 3'b000, 3'b000, 3'b000, 3'b000, 3'b000, 3'b111, 3'b111, 3'b111,
         3'b111, 3'b101, 3'b101, 3'b101, 3'b111, 3'b111, 3'b111, 3'b111, 3'b011,
         3'b011, 3'b011, 3'b011, 3'b111, 3'b110, 3'b110, 3'b111};
      live_cfg = '{SETTLE_RST, DEBOUNCE_RST, HOLD_RST, SLOW_RST, FAST_RST, ACCEL_RST,
                   NO_REPEAT_RST};
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      check_readback();

      // simultaneous edges, press, repeats, no-repeat button, release at settle time
      load_settings('{16'd1, 16'd3, 16'd1, 16'd2, 16'd1, 4'd1, 2'd1});
      foreach (opening[i]) queue_tick(opening[i]);
      wait_drained();

      repeat (3) run_random_phase(PHASE_TICKS);
      tx_idle_pct = 84;
      rx_idle_pct = 12;
      repeat (3) run_random_phase(PHASE_TICKS);
      tx_idle_pct = 0;
      rx_idle_pct = 0;

      // zero waits give a repeat every tick; the receiver backs off long enough to fill the block
      load_settings('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 4'd0, 2'd3});
      stalls_asked++;
      queue_tick(ALL_UP);
      repeat (150) queue_tick(3'b110);
      repeat (5) queue_tick(ALL_UP);
      wait_drained();

      repeat (3) run_random_phase(PHASE_TICKS);

      // longer waits: press after the settle, slow repeats then fast ones; the release
      // leaves a fast repeat interval part way through so the next settings apply to a wait in progress
      load_settings('{16'd20, 16'd40, 16'd30, 16'd25, 16'd10, 4'd2, 2'd3});
      queue_tick(ALL_UP);
      repeat (100) queue_tick(3'b011);
      repeat (4) queue_tick(ALL_UP);
      wait_drained();

      run_random_phase(PHASE_TICKS);

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
